[rtl/csfh_pkg.sv]
`default_nettype none

package csfh_pkg;

   // byte mapping
   localparam logic [7:0] BACKSLASH   = 8'h5C;
   localparam logic [7:0] SLASH_DELTA = 8'd45;
   localparam logic [7:0] FOLD_MASK   = 8'hDF;

   // running hash multiplier (27 significant bits)
   localparam logic [31:0] MUL_STATE = 32'h0633_D5F1;

   // word multiplier 0xFB8C4D96501 split at bit 32
   localparam logic [31:0] MUL_WORD_LO = 32'hC4D9_6501;
   localparam logic [11:0] MUL_WORD_HI = 12'hFB8;

   // length correction multiplier, its four-byte step and its weight at 2^32
   localparam logic [63:0] MUL_LENGTH  = 64'h00AE_5028_12AA_7333;
   localparam logic [63:0] LENGTH_STEP = MUL_LENGTH << 2;
   localparam logic [63:0] LENGTH_WRAP = MUL_LENGTH << 32;

   localparam int unsigned WORD_SHIFT = 24;

   typedef logic [1:0] byte_pos_type;

   // backslash to slash, then clear bit 5
   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      logic [7:0] m;
      m = (b == BACKSLASH) ? (b - SLASH_DELTA) : b;
      return m & FOLD_MASK;
   endfunction

   // length correction for the bytes of the last word
   function automatic logic [63:0] tail_corr(input byte_pos_type pos);
      return MUL_LENGTH * {62'b0, pos};
   endfunction

endpackage

`default_nettype wire

[rtl/case_folding_string_guid_hash.sv]
`default_nettype none

// a result is valid once the item holding the terminator has passed stages a to d
// throughput: one item per cycle unless rsp_ready stalls; the hash recurrence closes
// in running_hash_ff (two 32-bit constant multiplies, three-input add, shift-xor fold)
// stages with no item in them fill while the result register waits
// reset: synchronous, clears all stage valids and the running hash, byte count and
// length correction; no clearing pass, the first item can be accepted right after reset
module case_folding_string_guid_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_chars,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash,
   output logic [31:0]      rsp_length
);
   import csfh_pkg::*;

   // stage enables: a stage loads when it is empty or its successor loads
   logic en_a, en_b, en_c, en_d, en_o;

   // stage a: input register
   logic        va_ff;
   logic [31:0] a_chars_ff;

   // stage b: partial products of the folded word
   logic         vb_ff;
   logic [63:0]  b_plo_ff;
   logic [31:0]  b_phi_ff;
   logic         b_term_ff;
   byte_pos_type b_pos_ff;

   // stage c: shifted word term
   logic         vc_ff;
   logic [39:0]  c_word_ff;
   logic         c_term_ff;
   byte_pos_type c_pos_ff;

   // stage d: final sum and length of a finished string
   logic        vd_ff;
   logic [63:0] d_sum_ff;
   logic [63:0] d_corr_ff;
   logic [31:0] d_len_ff;

   // result register
   logic        vo_ff;
   logic [63:0] o_hash_ff;
   logic [31:0] o_len_ff;

   // per-string state
   logic [63:0] running_hash_ff, running_hash_in;
   logic [31:0] bytes_seen_ff, bytes_seen_in;
   logic [63:0] corr_ff, corr_in;    // MUL_LENGTH * bytes_seen, kept incrementally

   assign en_o = !vo_ff || rsp_ready;
   assign en_d = !vd_ff || en_o;
   assign en_c = !vc_ff || en_d;
   assign en_b = !vb_ff || en_c;
   assign en_a = !va_ff || en_b;
   assign req_ready = en_a;

   // ---------------------------------------------------------------------
   // stage a -> b: terminator search, mask, fold and word multiply
   // ---------------------------------------------------------------------
   logic [3:0]   nz;
   logic [3:0]   keep;
   logic [31:0]  folded;
   logic         a_term;
   byte_pos_type a_pos;
   logic [63:0]  a_plo;
   logic [31:0]  a_phi;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         nz[b] = (a_chars_ff[8*b +: 8] != 8'h00);
      end
      // a byte survives only if it and every byte before it are nonzero
      keep[0] = nz[0];
      keep[1] = keep[0] & nz[1];
      keep[2] = keep[1] & nz[2];
      keep[3] = keep[2] & nz[3];
      for (int b = 0; b < 4; b++) begin
         folded[8*b +: 8] = keep[b] ? fold_byte(a_chars_ff[8*b +: 8]) : 8'h00;
      end
      a_term = !keep[3];
      // lowest zero byte ends the string
      if (!nz[0]) begin
         a_pos = 2'd0;
      end else if (!nz[1]) begin
         a_pos = 2'd1;
      end else if (!nz[2]) begin
         a_pos = 2'd2;
      end else begin
         a_pos = 2'd3;
      end
      // word times 0xFB8C4D96501 as a full low product and a truncated high one
      a_plo = {32'b0, folded} * {32'b0, MUL_WORD_LO};
      a_phi = folded * {20'b0, MUL_WORD_HI};
   end

   // ---------------------------------------------------------------------
   // stage b -> c: combine partial products, keep bits 63:24
   // ---------------------------------------------------------------------
   logic [63:0] b_full;
   assign b_full = b_plo_ff + {b_phi_ff, 32'b0};

   // ---------------------------------------------------------------------
   // stage c -> d: hash recurrence, runs once per word
   // ---------------------------------------------------------------------
   logic [63:0] st_plo;
   logic [31:0] st_phi;
   logic [63:0] sum;
   logic        step;
   logic [31:0] len;
   logic        count_wrap;

   assign step   = vc_ff && en_d;
   assign st_plo = {32'b0, running_hash_ff[31:0]} * {32'b0, MUL_STATE};
   assign st_phi = running_hash_ff[63:32] * MUL_STATE;
   assign sum    = st_plo + {st_phi, 32'b0} + {24'b0, c_word_ff};
   assign len    = bytes_seen_ff + {30'b0, c_pos_ff};
   // byte count is a multiple of four, so it wraps when its upper bits are all ones
   assign count_wrap = &bytes_seen_ff[31:2];

   always_comb begin
      running_hash_in = running_hash_ff;
      bytes_seen_in   = bytes_seen_ff;
      corr_in         = corr_ff;
      if (step) begin
         if (c_term_ff) begin
            // string done: next word starts from cleared state
            running_hash_in = 64'b0;
            bytes_seen_in   = 32'b0;
            corr_in         = 64'b0;
         end else begin
            running_hash_in = sum ^ (sum >> 61);
            bytes_seen_in   = bytes_seen_ff + 32'd4;
            // on a count wrap the correction drops the 2^32 term as well
            corr_in         = corr_ff + LENGTH_STEP - (count_wrap ? LENGTH_WRAP : 64'b0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff           <= 1'b0;
         vb_ff           <= 1'b0;
         vc_ff           <= 1'b0;
         vd_ff           <= 1'b0;
         vo_ff           <= 1'b0;
         running_hash_ff <= 64'b0;
         bytes_seen_ff   <= 32'b0;
         corr_ff         <= 64'b0;
      end else begin
         if (en_a) va_ff <= req_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
         // only a word holding the terminator yields a result
         if (en_d) vd_ff <= vc_ff && c_term_ff;
         if (en_o) vo_ff <= vd_ff;
         running_hash_ff <= running_hash_in;
         bytes_seen_ff   <= bytes_seen_in;
         corr_ff         <= corr_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (en_a) begin
         a_chars_ff <= req_chars;
      end
      if (en_b) begin
         b_plo_ff  <= a_plo;
         b_phi_ff  <= a_phi;
         b_term_ff <= a_term;
         b_pos_ff  <= a_pos;
      end
      if (en_c) begin
         c_word_ff <= b_full[63:WORD_SHIFT];
         c_term_ff <= b_term_ff;
         c_pos_ff  <= b_pos_ff;
      end
      if (en_d) begin
         d_sum_ff  <= sum;
         d_corr_ff <= corr_ff + tail_corr(c_pos_ff);
         d_len_ff  <= len;
      end
      if (en_o) begin
         o_hash_ff <= d_sum_ff - d_corr_ff;
         o_len_ff  <= d_len_ff;
      end
   end

   assign rsp_valid  = vo_ff;
   assign rsp_hash   = o_hash_ff;
   assign rsp_length = o_len_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // with the result register empty the whole pipe can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !vo_ff |-> req_ready)
      else $error("input stalled with empty result register");

   // a finished string leaves cleared state behind
   a_clear_after_string: assert property (@(posedge clock) disable iff (reset)
      (step && c_term_ff) |=> (running_hash_ff == 64'b0 && bytes_seen_ff == 32'b0
                               && corr_ff == 64'b0))
      else $error("state not cleared after string");

   // each unterminated word adds four bytes
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (step && !c_term_ff) |=> (bytes_seen_ff == $past(bytes_seen_ff) + 32'd4))
      else $error("byte count did not advance by four");

   // correction register tracks the byte count
   a_corr_tracks: assert property (@(posedge clock) disable iff (reset)
      corr_ff == MUL_LENGTH * {32'b0, bytes_seen_ff})
      else $error("length correction out of step with byte count");

   // a pending string result holds while the result register is blocked
   a_d_hold: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && !en_o) |=> (vd_ff && $stable(d_sum_ff) && $stable(d_len_ff)))
      else $error("pending result changed while stalled");

endmodule

`default_nettype wire

[tb/tb_case_folding_string_guid_hash.sv]
`default_nettype none

module tb_case_folding_string_guid_hash;
   timeunit 1ns;
   timeprecision 1ps;

   // hash constants
   localparam logic [63:0] STATE_MUL  = 64'h0000_0000_0633_D5F1;
   localparam logic [63:0] WORD_MUL   = 64'h0000_0FB8_C4D9_6501;
   localparam logic [63:0] LENGTH_MUL = 64'h00AE_5028_12AA_7333;
   localparam logic [7:0]  BSLASH_CHAR = 8'h5C;
   localparam logic [7:0]  SLASH_OFFSET = 8'd45;
   localparam logic [7:0]  CASE_MASK   = 8'hDF;

   // stimulus shape
   localparam int unsigned TOTAL_WORDS  = 1620;
   localparam int unsigned CALM_FROM    = 1450;   // no idling past this word count
   localparam int unsigned DRAIN_CYCLES = 10;

   // one finished string: its hash and its length
   typedef struct packed {
      logic [63:0] hash;
      logic [31:0] length;
   } digest_type;

   // predicts the digest of every string and checks results in order
   class guid_hash_scoreboard;
      logic [63:0] hash_acc;
      logic [31:0] bytes_seen;
      digest_type  expected_digests[$];
      int          errors;

      function new();
         hash_acc   = '0;
         bytes_seen = '0;
         errors     = 0;
      endfunction

      // accepted input word: advance the running hash, queue a digest on the terminator
      function void note_word(logic [31:0] w);
         logic [31:0]  kept;
         logic [31:0]  folded;
         logic [7:0]   c;
         logic         ended;
         int unsigned  zero_at;
         logic [63:0]  sum;
         digest_type   d;
         kept    = '0;
         ended   = 1'b0;
         zero_at = 0;
         for (int b = 0; b < 4; b++) begin
            c = w[8*b +: 8];
            if (!ended) begin
               if (c == 8'h00) begin
                  ended   = 1'b1;
                  zero_at = b;
               end else begin
                  kept[8*b +: 8] = c;
               end
            end
         end
         folded = '0;
         for (int b = 0; b < 4; b++) begin
            c = kept[8*b +: 8];
            if (c == BSLASH_CHAR) begin
               c = c - SLASH_OFFSET;
            end
            folded[8*b +: 8] = c & CASE_MASK;
         end
         sum = STATE_MUL * hash_acc + ((WORD_MUL * {32'b0, folded}) >> 24);
         if (ended) begin
            d.length = bytes_seen + zero_at;
            d.hash   = sum - LENGTH_MUL * {32'b0, d.length};
            expected_digests = {expected_digests, d};
            hash_acc   = '0;
            bytes_seen = '0;
         end else begin
            hash_acc   = sum ^ (sum >> 61);
            bytes_seen = bytes_seen + 32'd4;
         end
      endfunction

      // accepted result: compare with the oldest queued digest
      function void check_result(logic [63:0] hash, logic [31:0] length);
         digest_type d;
         if (expected_digests.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual hash %h length %0d",
                     $time, hash, length);
            errors++;
            return;
         end
         d = expected_digests.pop_front();
         if (hash !== d.hash) begin
            $display("%0t: hash mismatch, expected %h actual %h", $time, d.hash, hash);
            errors++;
         end
         if (length !== d.length) begin
            $display("%0t: length mismatch, expected %0d actual %0d",
                     $time, d.length, length);
            errors++;
         end
      endfunction

      function int pending();
         return expected_digests.size();
      endfunction
   endclass

   // dut signals, all inputs known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_ready;
   logic [31:0] req_chars  = '0;
   logic        rsp_valid;
   logic        rsp_ready  = 1'b0;
   logic [63:0] rsp_hash;
   logic [31:0] rsp_length;

   guid_hash_scoreboard sb = new();

   // idling switch, shared by the sender and the receiver
   logic        idle_on    = 1'b1;
   int unsigned word_count = 0;
   int unsigned stall_left = 0;

   case_folding_string_guid_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_chars  (req_chars),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_hash   (rsp_hash),
      .rsp_length (rsp_length)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // watch both channels at every edge; values read here are the ones the dut saw
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_word(req_chars);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_hash, rsp_length);
         end
      end
   end

   // result side back-pressure: random stall bursts while idling is on
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one item on the input channel; valid stays up between back-to-back items
   task automatic send_word(input logic [31:0] w);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chars <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      word_count++;
   endtask

   // a nonzero character, biased toward letters and path separators
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 5))
         0: return 8'h61 + 8'($urandom_range(0, 25));   // lower case
         1: return 8'h41 + 8'($urandom_range(0, 25));   // upper case
         2: return BSLASH_CHAR;
         3: return 8'h2F;                               // forward slash
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // a string of n full words, then a word holding the terminator
   // at a random position with random bytes after it
   task automatic send_string(input int unsigned n_words);
      logic [31:0] w;
      int unsigned pos;
      for (int i = 0; i < n_words; i++) begin
         for (int b = 0; b < 4; b++) begin
            w[8*b +: 8] = pick_char();
         end
         send_word(w);
      end
      pos = $urandom_range(0, 3);
      w   = $urandom;
      for (int b = 0; b < pos; b++) begin
         w[8*b +: 8] = pick_char();
      end
      w[8*pos +: 8] = 8'h00;
      send_word(w);
   endtask

   // main sequence
   initial begin
      int unsigned n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty string, extremes, backslashes, case pairs,
      // terminator at each byte with junk after it, several zeros in one word
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'h5C5C_5C5C);
      send_word(32'h005C_5C5C);
      send_word(32'h6463_6261);     // abcd
      send_word(32'h4443_4241);     // ABCD
      send_word(32'h0000_0000);
      send_word(32'h00FF_FFFF);     // terminator in the top byte
      send_word(32'hFF00_FFFF);     // terminator in byte 2, junk after
      send_word(32'hFFFF_00FF);     // terminator in byte 1, junk after
      send_word(32'hFFFF_FF00);     // terminator in byte 0, junk after
      send_word(32'h0000_0061);     // zeros in three bytes
      send_word(32'h0000_FF7A);
      send_word(32'h8080_8080);
      send_word(32'h0101_0101);
      send_word(32'h2020_2020);
      send_word(32'hDC00_7F5C);

      // random: mostly well-formed strings, some raw noise words;
      // idling comes and goes in segments and stops for the last part
      while (word_count < TOTAL_WORDS) begin
         idle_on <= (word_count < CALM_FROM) && ((word_count / 150) % 3 != 2);
         if ($urandom_range(0, 6) == 0) begin
            send_word($urandom);
         end else begin
            if ($urandom_range(0, 15) == 0) n = $urandom_range(7, 40);
            else n = $urandom_range(0, 6);
            send_string(n);
         end
      end
      req_valid <= 1'b0;
      idle_on   <= 1'b0;
      @(posedge clock);

      // drain, then let the pipeline settle so stray results show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

[case_folding_string_guid_hash.f]
rtl/csfh_pkg.sv
rtl/case_folding_string_guid_hash.sv
tb/tb_case_folding_string_guid_hash.sv
